FILE: design/bfhp_pkg.sv
// ----------------------------------------------------------------------------
// Bitstream file header parser package
// Shared phase and status codes, header constants and the result record.
// ----------------------------------------------------------------------------
package bfhp_pkg;

    localparam logic [7:0]  MAGIC_EVEN = 8'h0f;
    localparam logic [7:0]  MAGIC_ODD  = 8'hf0;
    localparam logic [15:0] END_WORD   = 16'h0001;
    localparam logic [7:0]  PREFIX_A   = 8'h61;
    localparam logic [7:0]  PREFIX_E   = 8'h65;
    localparam logic [15:0] BLEN_BYTES = 16'd4;
    localparam logic [1:0]  LAST_STR   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_MAGIC,
        PH_NULL,
        PH_WORD_HI,
        PH_WORD_LO,
        PH_PREFIX,
        PH_SLEN_HI,
        PH_SLEN_LO,
        PH_STR,
        PH_E,
        PH_BLEN
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK,
        ST_SHORT,
        ST_MAGIC_LEN,
        ST_MAGIC_BYTE,
        ST_END_LEN,
        ST_END_WORD,
        ST_STR_A,
        ST_STR_B,
        ST_STR_C,
        ST_STR_D,
        ST_NO_LENGTH,
        ST_BAD_E
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] hdr_size;
        logic [31:0] stream_size;
        logic [15:0] magic_size;
        logic [31:0] design_offset;
        logic [15:0] design_length;
        logic [31:0] part_offset;
        logic [15:0] part_length;
        logic [31:0] date_offset;
        logic [15:0] date_length;
        logic [31:0] time_offset;
        logic [15:0] time_length;
    } result_t;

    function automatic status_t str_code(input logic [1:0] idx);
        status_t code;
        case (idx)
            2'd0:    code = ST_STR_A;
            2'd1:    code = ST_STR_B;
            2'd2:    code = ST_STR_C;
            default: code = ST_STR_D;
        endcase
        return code;
    endfunction

endpackage

FILE: design/bfhp_core.sv
// ----------------------------------------------------------------------------
// Bitstream file header parser core
// Holds the parse state and works one header byte per step into a result.
// ----------------------------------------------------------------------------
module bfhp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              start,
    input  logic [31:0]       buffer_length,
    output logic              res_fire,
    output bfhp_pkg::result_t res
);
    import bfhp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [31:0]        byte_pos_reg, byte_pos_next;
    logic [15:0]        field_cnt_reg, field_cnt_next;
    logic [15:0]        field_len_reg, field_len_next;
    logic [31:0]        acc_reg, acc_next;
    logic [1:0]         str_idx_reg, str_idx_next;
    logic [15:0]        magic_len_reg, magic_len_next;
    logic [3:0][31:0]   saved_pos_reg, saved_pos_next;
    logic [3:0][15:0]   saved_len_reg, saved_len_next;

    phase_t      eff_phase;
    logic        short_buf;
    logic        active;
    logic [31:0] pos;
    logic [15:0] v16;
    logic [32:0] len33;
    logic        fit_bad;
    logic        room3_bad;
    logic        room5_bad;
    logic [15:0] fc_inc;
    logic        magic_done;
    logic        str_done;
    logic [7:0]  magic_exp;
    logic [7:0]  prefix_exp;
    status_t     res_code;

    assign eff_phase  = start ? PH_LEN_HI : phase_reg;
    assign short_buf  = start && (buffer_length < 32'd2);
    assign active     = step && !short_buf && (eff_phase != PH_IDLE);
    assign pos        = (start ? 32'd0 : byte_pos_reg) + 32'd1;
    assign v16        = {field_len_reg[15:8], data_byte};
    assign len33      = {1'b0, buffer_length};
    assign fit_bad    = ({1'b0, pos} + {17'd0, v16}) > len33;
    assign room3_bad  = ({1'b0, pos} + 33'd3) > len33;
    assign room5_bad  = ({1'b0, pos} + 33'd5) >= len33;
    assign fc_inc     = field_cnt_reg + 16'd1;
    assign magic_done = ({1'b0, fc_inc} + 17'd1) >= {1'b0, field_len_reg};
    assign str_done   = fc_inc >= field_len_reg;
    assign magic_exp  = field_cnt_reg[0] ? MAGIC_ODD : MAGIC_EVEN;
    assign prefix_exp = PREFIX_A + {6'd0, str_idx_reg};

    // Next phase, string index and result code.
    always_comb
    begin
        phase_next   = phase_reg;
        str_idx_next = str_idx_reg;
        res_fire     = 1'b0;
        res_code     = ST_OK;
        if (step && short_buf)
        begin
            phase_next = PH_IDLE;
            res_fire   = 1'b1;
            res_code   = ST_SHORT;
        end
        else if (active)
        begin
            if (start)
                str_idx_next = 2'd0;
            unique case (eff_phase)
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:
                begin
                    if (fit_bad)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_MAGIC_LEN;
                    end
                    else if (v16 <= 16'd1)
                    begin
                        if (room3_bad)
                        begin
                            phase_next = PH_IDLE;
                            res_fire   = 1'b1;
                            res_code   = ST_END_LEN;
                        end
                        else
                            phase_next = PH_NULL;
                    end
                    else
                        phase_next = PH_MAGIC;
                end
                PH_MAGIC:
                begin
                    if (data_byte != magic_exp)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_MAGIC_BYTE;
                    end
                    else if (magic_done)
                    begin
                        if (room3_bad)
                        begin
                            phase_next = PH_IDLE;
                            res_fire   = 1'b1;
                            res_code   = ST_END_LEN;
                        end
                        else
                            phase_next = PH_NULL;
                    end
                end
                PH_NULL:
                begin
                    if (data_byte != 8'd0)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_END_WORD;
                    end
                    else
                        phase_next = PH_WORD_HI;
                end
                PH_WORD_HI: phase_next = PH_WORD_LO;
                PH_WORD_LO:
                begin
                    str_idx_next = 2'd0;
                    if (v16 != END_WORD)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_END_WORD;
                    end
                    else if (room3_bad)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_STR_A;
                    end
                    else
                        phase_next = PH_PREFIX;
                end
                PH_PREFIX:
                begin
                    if (data_byte != prefix_exp)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = str_code(str_idx_reg);
                    end
                    else
                        phase_next = PH_SLEN_HI;
                end
                PH_SLEN_HI: phase_next = PH_SLEN_LO;
                PH_SLEN_LO, PH_STR:
                begin
                    if ((eff_phase == PH_SLEN_LO) && fit_bad)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = str_code(str_idx_reg);
                    end
                    else if ((eff_phase == PH_SLEN_LO) && (v16 != 16'd0))
                        phase_next = PH_STR;
                    else if ((eff_phase == PH_STR) && !str_done)
                        phase_next = PH_STR;
                    else if ((eff_phase == PH_STR) && (data_byte != 8'd0))
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = str_code(str_idx_reg);
                    end
                    else if (str_idx_reg != LAST_STR)
                    begin
                        // End of string: move to the next prefix if it fits.
                        str_idx_next = str_idx_reg + 2'd1;
                        if (room3_bad)
                        begin
                            phase_next = PH_IDLE;
                            res_fire   = 1'b1;
                            res_code   = str_code(str_idx_reg + 2'd1);
                        end
                        else
                            phase_next = PH_PREFIX;
                    end
                    else if (room5_bad)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_NO_LENGTH;
                    end
                    else
                        phase_next = PH_E;
                end
                PH_E:
                begin
                    if (data_byte != PREFIX_E)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_BAD_E;
                    end
                    else
                        phase_next = PH_BLEN;
                end
                PH_BLEN:
                begin
                    if (fc_inc >= BLEN_BYTES)
                    begin
                        phase_next = PH_IDLE;
                        res_fire   = 1'b1;
                        res_code   = ST_OK;
                    end
                end
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // Counters, lengths and saved string positions.
    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        field_cnt_next = field_cnt_reg;
        field_len_next = field_len_reg;
        acc_next       = acc_reg;
        magic_len_next = magic_len_reg;
        saved_pos_next = saved_pos_reg;
        saved_len_next = saved_len_reg;
        if (step && start)
            byte_pos_next = 32'd0;
        if (active)
        begin
            byte_pos_next = pos;
            case (eff_phase)
                PH_LEN_HI, PH_WORD_HI, PH_SLEN_HI:
                    field_len_next = {data_byte, 8'd0};
                PH_LEN_LO:
                begin
                    if (!fit_bad)
                    begin
                        magic_len_next = v16;
                        field_len_next = v16;
                        field_cnt_next = 16'd0;
                    end
                end
                PH_MAGIC:
                begin
                    if (data_byte == magic_exp)
                        field_cnt_next = fc_inc;
                end
                PH_SLEN_LO:
                begin
                    if (!fit_bad)
                    begin
                        field_len_next              = v16;
                        field_cnt_next              = 16'd0;
                        saved_pos_next[str_idx_reg] = pos;
                        saved_len_next[str_idx_reg] = v16;
                    end
                end
                PH_STR:
                    field_cnt_next = fc_inc;
                PH_E:
                begin
                    field_cnt_next = 16'd0;
                    acc_next       = 32'd0;
                end
                PH_BLEN:
                begin
                    acc_next       = {acc_reg[23:0], data_byte};
                    field_cnt_next = fc_inc;
                end
                default:
                begin
                    field_cnt_next = field_cnt_reg;
                end
            endcase
        end
    end

    // Result record: fields stay zero on any error.
    always_comb
    begin
        res        = '0;
        res.status = res_code;
        if (res_code == ST_OK)
        begin
            res.hdr_size      = pos;
            res.stream_size   = acc_next;
            res.magic_size    = magic_len_reg;
            res.design_offset = saved_pos_reg[0];
            res.design_length = saved_len_reg[0];
            res.part_offset   = saved_pos_reg[1];
            res.part_length   = saved_len_reg[1];
            res.date_offset   = saved_pos_reg[2];
            res.date_length   = saved_len_reg[2];
            res.time_offset   = saved_pos_reg[3];
            res.time_length   = saved_len_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            byte_pos_reg  <= '0;
            field_cnt_reg <= '0;
            field_len_reg <= '0;
            str_idx_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            byte_pos_reg  <= byte_pos_next;
            field_cnt_reg <= field_cnt_next;
            field_len_reg <= field_len_next;
            str_idx_reg   <= str_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        magic_len_reg <= magic_len_next;
        saved_pos_reg <= saved_pos_next;
        saved_len_reg <= saved_len_next;
    end

endmodule

FILE: design/bitstream_file_header_parser.sv
// ----------------------------------------------------------------------------
// Bitstream file header parser
// Streams header bytes through the file header checks, one result per parse.
// ----------------------------------------------------------------------------
// Usage:
//   Write buffer_length on the cfg channel (cfg_valid/cfg_ready) while no
//   parse is pending; cfg_ready is always high. Send header bytes on the
//   input channel (in_valid/in_ready) in buffer order, start_flag set on
//   byte 0. Bytes outside a parse are dropped with no result.
//   One result item per parse appears on the output channel
//   (out_valid/out_ready): status plus, on success, the header length,
//   bitstream length, magic length and the four string offsets/lengths.
//   A result is registered: its byte lands in the input register, and the
//   parse step then writes the output register when the result side allows.
//   Throughput: one byte per cycle while the output side does not stall,
//   set by the single parse step between the input register and the output
//   register.
//   Stall: while out_ready is low and a result is held, the parse step
//   holds; the input register still fills, then in_ready drops.
//   Reset: rst_n clears all control state; buffer_length returns to zero and
//   the parser waits for a start byte.
// ----------------------------------------------------------------------------
module bitstream_file_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] buffer_length,
    // header bytes
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_flag,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] hdr_size,
    output logic [31:0] stream_size,
    output logic [15:0] magic_size,
    output logic [31:0] design_offset,
    output logic [15:0] design_length,
    output logic [31:0] part_offset,
    output logic [15:0] part_length,
    output logic [31:0] date_offset,
    output logic [15:0] date_length,
    output logic [31:0] time_offset,
    output logic [15:0] time_length
);
    import bfhp_pkg::*;

    logic [31:0] buf_len_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    result_t     result_reg;

    logic        out_load;
    logic        step;
    logic        res_fire;
    result_t     res;

    // The output register can take a new result when empty or being drained.
    assign out_load  = !out_valid_reg || out_ready;
    // Advance the held byte through the parse step when the result side allows.
    assign step      = in_valid_reg && out_load;
    assign in_ready  = !in_valid_reg || out_load;
    assign cfg_ready = 1'b1;

    bfhp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (in_byte_reg),
        .start         (in_start_reg),
        .buffer_length (buf_len_reg),
        .res_fire      (res_fire),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg   <= '0;
            in_valid_reg  <= 1'b0;
            in_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                buf_len_reg <= buffer_length;
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
                in_start_reg <= start_flag;
            end
            if (out_load)
                out_valid_reg <= step && res_fire;
        end
    end

    // Payload registers: capture the byte and the result, no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready)
            in_byte_reg <= data_byte;
        if (step && res_fire)
            result_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign hdr_size      = result_reg.hdr_size;
    assign stream_size   = result_reg.stream_size;
    assign magic_size    = result_reg.magic_size;
    assign design_offset = result_reg.design_offset;
    assign design_length = result_reg.design_length;
    assign part_offset   = result_reg.part_offset;
    assign part_length   = result_reg.part_length;
    assign date_offset   = result_reg.date_offset;
    assign date_length   = result_reg.date_length;
    assign time_offset   = result_reg.time_offset;
    assign time_length   = result_reg.time_length;

endmodule
